// ----- rtl/xonbuf_pkg.sv -----
// Shared constants, codes and types of the XON/XOFF receive buffer.
package xonbuf_pkg;

   // Store geometry
   localparam int FIFO_DEPTH = 16;
   localparam int ADDR_W     = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // Field widths
   localparam int BYTE_W     = 8;
   localparam int THR_W      = 5;
   localparam int FILL_W     = 5;
   localparam int FLOW_W     = 2;
   localparam int CMP_W      = (CNT_W > THR_W) ? CNT_W : THR_W;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Register reset values
   localparam logic [THR_W-1:0]  UPPER_RESET  = THR_W'(5);
   localparam logic [THR_W-1:0]  LOWER_RESET  = THR_W'(2);
   localparam logic [BYTE_W-1:0] MARKER_RESET = BYTE_W'(26);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER      = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER = CSR_IDX_W'(2);

   // Request opcodes
   localparam logic OP_RX      = 1'b0;
   localparam logic OP_CONSUME = 1'b1;

   // Flow control events
   localparam logic [FLOW_W-1:0] FLOW_NONE = FLOW_W'(0);
   localparam logic [FLOW_W-1:0] FLOW_XON  = FLOW_W'(1);
   localparam logic [FLOW_W-1:0] FLOW_XOFF = FLOW_W'(2);

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_LOAD
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic step;   // accepted beat: update pointers, count, flow state
      logic load;   // load the result register
   } dp_cmd_type;

endpackage

// ----- rtl/xonbuf_if.sv -----
// Request and response channel interfaces of the XON/XOFF receive buffer.
interface xonbuf_req_if;
   logic                             valid;
   logic                             ready;
   logic                             opcode;
   logic [xonbuf_pkg::BYTE_W-1:0]    rx_byte;

   modport source (output valid, output opcode, output rx_byte, input ready);
   modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface xonbuf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             pop_valid;
   logic [xonbuf_pkg::BYTE_W-1:0]    pop_byte;
   logic [xonbuf_pkg::FLOW_W-1:0]    flow_event;
   logic                             dropped;
   logic                             end_seen;
   logic [xonbuf_pkg::FILL_W-1:0]    fill_count;
   logic                             receiving;

   modport source (output valid, output pop_valid, output pop_byte, output flow_event,
                   output dropped, output end_seen, output fill_count, output receiving,
                   input ready);
   modport sink   (input valid, input pop_valid, input pop_byte, input flow_event,
                   input dropped, input end_seen, input fill_count, input receiving,
                   output ready);
endinterface

// ----- rtl/xon_xoff_receive_buffer.sv -----
// Top level of the XON/XOFF receive buffer: controller, datapath and channels.
//
//   channel   direction  handshake      payload
//   req_chan  in         valid/ready    opcode, rx_byte
//   rsp_chan  out        valid/ready    pop_valid, pop_byte, flow_event, dropped,
//                                       end_seen, fill_count, receiving
//   csr_*     in         csr_we         csr_index, csr_wdata
//
// Each item has an accept state and a load state: accepting updates pointers, count
// and flow state and issues the store read; the load state loads the result register
// from the registered store output. Reset is synchronous and clears pointers, count
// and flow state and restores the register defaults; store contents are not cleared.
// A stalled result holds in the output register; the next item is accepted while it
// waits, and its load stage holds until the output register drains.
module xon_xoff_receive_buffer (
   input  logic                                 clock,
   input  logic                                 reset,
   xonbuf_req_if.sink                           req_chan,
   xonbuf_rsp_if.source                         rsp_chan,
   input  logic                                 csr_we,
   input  logic [xonbuf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [xonbuf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   xonbuf_pkg::dp_cmd_type cmd;

   xonbuf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   xonbuf_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_opcode     (req_chan.opcode),
      .req_rx_byte    (req_chan.rx_byte),
      .rsp_pop_valid  (rsp_chan.pop_valid),
      .rsp_pop_byte   (rsp_chan.pop_byte),
      .rsp_flow_event (rsp_chan.flow_event),
      .rsp_dropped    (rsp_chan.dropped),
      .rsp_end_seen   (rsp_chan.end_seen),
      .rsp_fill_count (rsp_chan.fill_count),
      .rsp_receiving  (rsp_chan.receiving)
   );

endmodule

// ----- rtl/xonbuf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module xonbuf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/xonbuf_ctrl.sv -----
// Controller of the XON/XOFF receive buffer: request/response sequencing.
module xonbuf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output xonbuf_pkg::dp_cmd_type cmd
);

   xonbuf_pkg::state_type state_ff, state_in;
   logic                  out_full_ff, out_full_in;

   // State and result-register occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= xonbuf_pkg::ST_IDLE;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_full_ff <= out_full_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.step    = 1'b0;
      cmd.load    = 1'b0;
      unique case (state_ff)
         xonbuf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.step = 1'b1;
               state_in = xonbuf_pkg::ST_LOAD;
            end
         end
         xonbuf_pkg::ST_LOAD: begin
            // load once the result register is free or being drained
            if (!out_full_ff || rsp_ready) begin
               cmd.load = 1'b1;
               state_in = xonbuf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = xonbuf_pkg::ST_IDLE;
         end
      endcase
   end

   // Track whether a result beat waits at the output
   always_comb begin
      out_full_in = out_full_ff;
      if (cmd.load) begin
         out_full_in = 1'b1;
      end else if (rsp_ready) begin
         out_full_in = 1'b0;
      end
   end

   assign rsp_valid = out_full_ff;

endmodule

// ----- rtl/xonbuf_dp.sv -----
// Datapath of the XON/XOFF receive buffer: registers, pointers, flow state, result.
module xonbuf_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  xonbuf_pkg::dp_cmd_type               cmd,
   input  logic                                 csr_we,
   input  logic [xonbuf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [xonbuf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                 req_opcode,
   input  logic [xonbuf_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                                 rsp_pop_valid,
   output logic [xonbuf_pkg::BYTE_W-1:0]        rsp_pop_byte,
   output logic [xonbuf_pkg::FLOW_W-1:0]        rsp_flow_event,
   output logic                                 rsp_dropped,
   output logic                                 rsp_end_seen,
   output logic [xonbuf_pkg::FILL_W-1:0]        rsp_fill_count,
   output logic                                 rsp_receiving
);

   // Configuration registers
   logic [xonbuf_pkg::THR_W-1:0]  upper_ff;
   logic [xonbuf_pkg::THR_W-1:0]  lower_ff;
   logic [xonbuf_pkg::BYTE_W-1:0] marker_ff;

   // Buffer state
   logic [xonbuf_pkg::ADDR_W-1:0] head_ff, head_in;
   logic [xonbuf_pkg::ADDR_W-1:0] tail_ff, tail_in;
   logic [xonbuf_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                          xon_ff, xon_in;

   // Step outcome held for the load cycle
   logic                          pend_pop_ff;
   logic [xonbuf_pkg::FLOW_W-1:0] pend_flow_ff;
   logic                          pend_drop_ff;
   logic                          pend_end_ff;

   // Result register
   logic                          out_pop_valid_ff;
   logic [xonbuf_pkg::BYTE_W-1:0] out_pop_byte_ff;
   logic [xonbuf_pkg::FLOW_W-1:0] out_flow_ff;
   logic                          out_dropped_ff;
   logic                          out_end_seen_ff;
   logic [xonbuf_pkg::FILL_W-1:0] out_fill_ff;
   logic                          out_receiving_ff;

   // Step decode
   logic                          is_rx;
   logic                          push_ok;
   logic                          pop_ok;
   logic                          drop;
   logic                          xoff_ev;
   logic                          xon_ev;
   logic                          push_end;
   logic [xonbuf_pkg::CNT_W-1:0]  count_after_push;
   logic [xonbuf_pkg::FLOW_W-1:0] flow;
   logic [xonbuf_pkg::BYTE_W-1:0] rd_data;
   logic                          pop_end;

   // Write configuration registers, ignore indexes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff  <= xonbuf_pkg::UPPER_RESET;
         lower_ff  <= xonbuf_pkg::LOWER_RESET;
         marker_ff <= xonbuf_pkg::MARKER_RESET;
      end else if (csr_we) begin
         if (csr_index == xonbuf_pkg::CSR_UPPER) begin
            upper_ff <= csr_wdata[xonbuf_pkg::THR_W-1:0];
         end
         if (csr_index == xonbuf_pkg::CSR_LOWER) begin
            lower_ff <= csr_wdata[xonbuf_pkg::THR_W-1:0];
         end
         if (csr_index == xonbuf_pkg::CSR_END_MARKER) begin
            marker_ff <= csr_wdata[xonbuf_pkg::BYTE_W-1:0];
         end
      end
   end

   // Decode the accepted beat against the current state
   always_comb begin
      is_rx            = (req_opcode == xonbuf_pkg::OP_RX);
      push_ok          = is_rx && xon_ff &&
                         (count_ff < xonbuf_pkg::CNT_W'(xonbuf_pkg::FIFO_DEPTH));
      drop             = is_rx && !push_ok;
      count_after_push = count_ff + xonbuf_pkg::CNT_W'(push_ok);
      xoff_ev          = is_rx && xon_ff &&
                         (xonbuf_pkg::CMP_W'(count_after_push) > xonbuf_pkg::CMP_W'(upper_ff));
      pop_ok           = !is_rx && (count_ff != '0);
      xon_ev           = pop_ok && !xon_ff &&
                         (xonbuf_pkg::CMP_W'(count_ff) < xonbuf_pkg::CMP_W'(lower_ff));
      push_end         = push_ok && (req_rx_byte == marker_ff);
      if (xoff_ev) begin
         flow = xonbuf_pkg::FLOW_XOFF;
      end else if (xon_ev) begin
         flow = xonbuf_pkg::FLOW_XON;
      end else begin
         flow = xonbuf_pkg::FLOW_NONE;
      end
   end

   // Advance pointers, count and flow state on a step
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      xon_in   = xon_ff;
      if (cmd.step) begin
         if (push_ok) begin
            tail_in = (tail_ff == xonbuf_pkg::ADDR_W'(xonbuf_pkg::FIFO_DEPTH - 1)) ?
                      '0 : tail_ff + xonbuf_pkg::ADDR_W'(1);
         end
         if (pop_ok) begin
            head_in = (head_ff == xonbuf_pkg::ADDR_W'(xonbuf_pkg::FIFO_DEPTH - 1)) ?
                      '0 : head_ff + xonbuf_pkg::ADDR_W'(1);
         end
         if (push_ok) begin
            count_in = count_ff + xonbuf_pkg::CNT_W'(1);
         end else if (pop_ok) begin
            count_in = count_ff - xonbuf_pkg::CNT_W'(1);
         end
         if (xoff_ev) begin
            xon_in = 1'b0;
         end else if (xon_ev) begin
            xon_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         xon_ff   <= 1'b1;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         xon_ff   <= xon_in;
      end
   end

   // Hold the step outcome until the read data arrives
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         pend_pop_ff  <= pop_ok;
         pend_flow_ff <= flow;
         pend_drop_ff <= drop;
         pend_end_ff  <= push_end;
      end
   end

   // Byte store
   xonbuf_ram #(
      .WIDTH (xonbuf_pkg::BYTE_W),
      .DEPTH (xonbuf_pkg::FIFO_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.step && push_ok),
      .wr_addr (tail_ff),
      .wr_data (req_rx_byte),
      .rd_en   (cmd.step && pop_ok),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign pop_end = pend_pop_ff && (rd_data == marker_ff);

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_pop_valid_ff <= pend_pop_ff;
         out_pop_byte_ff  <= pend_pop_ff ? rd_data : '0;
         out_flow_ff      <= pend_flow_ff;
         out_dropped_ff   <= pend_drop_ff;
         out_end_seen_ff  <= pend_end_ff || pop_end;
         out_fill_ff      <= xonbuf_pkg::FILL_W'(count_ff);
         out_receiving_ff <= xon_ff;
      end
   end

   assign rsp_pop_valid  = out_pop_valid_ff;
   assign rsp_pop_byte   = out_pop_byte_ff;
   assign rsp_flow_event = out_flow_ff;
   assign rsp_dropped    = out_dropped_ff;
   assign rsp_end_seen   = out_end_seen_ff;
   assign rsp_fill_count = out_fill_ff;
   assign rsp_receiving  = out_receiving_ff;

endmodule

// ----- rtl/xonbuf_checker.sv -----
// Port-level checks of the XON/XOFF receive buffer, bound to the top level.
module xonbuf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              pop_valid,
   input logic [xonbuf_pkg::BYTE_W-1:0]     pop_byte,
   input logic [xonbuf_pkg::FLOW_W-1:0]     flow_event,
   input logic                              dropped,
   input logic                              receiving
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pop_byte) && $stable(flow_event))
      else $error("stalled result beat changed");

   // Flow event agrees with the reported receive state
   a_flow_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !((flow_event == xonbuf_pkg::FLOW_XOFF) && receiving) &&
                    !((flow_event == xonbuf_pkg::FLOW_XON) && !receiving))
      else $error("flow event disagrees with receive state");

   // A dropped arrival pops nothing and never turns XON
   a_drop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dropped |-> !pop_valid && (flow_event != xonbuf_pkg::FLOW_XON))
      else $error("dropped beat also popped or sent XON");

   // Zero byte when nothing was popped
   a_pop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !pop_valid |-> (pop_byte == '0))
      else $error("pop byte nonzero without pop");

endmodule

bind xon_xoff_receive_buffer xonbuf_checker u_xonbuf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .pop_valid  (rsp_chan.pop_valid),
   .pop_byte   (rsp_chan.pop_byte),
   .flow_event (rsp_chan.flow_event),
   .dropped    (rsp_chan.dropped),
   .receiving  (rsp_chan.receiving)
);

// ----- verif/xon_xoff_receive_buffer_test.sv -----
// Self-checking testbench of the XON/XOFF receive buffer: directed and random beats.
`timescale 1ns / 100ps

module xon_xoff_receive_buffer_test;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int PHASE_ITEMS    = 125;
   localparam int PHASE_COUNT    = 8;
   localparam logic [xonbuf_pkg::CSR_IDX_W-1:0] CSR_SPARE = xonbuf_pkg::CSR_IDX_W'(3);

   typedef struct {
      logic                            pop_valid;
      logic [xonbuf_pkg::BYTE_W-1:0]   pop_byte;
      logic [xonbuf_pkg::FLOW_W-1:0]   flow_event;
      logic                            dropped;
      logic                            end_seen;
      logic [xonbuf_pkg::FILL_W-1:0]   fill_count;
      logic                            receiving;
   } rsp_beat_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              csr_we;
   logic [xonbuf_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [xonbuf_pkg::CSR_DATA_W-1:0] csr_wdata;

   xonbuf_req_if req_if ();
   xonbuf_rsp_if rsp_if ();

   // Buffer state as the testbench tracks it
   logic [xonbuf_pkg::BYTE_W-1:0] ring [xonbuf_pkg::FIFO_DEPTH];
   logic [xonbuf_pkg::ADDR_W-1:0] rd_ptr;
   logic [xonbuf_pkg::ADDR_W-1:0] wr_ptr;
   int                            level;
   logic                          rx_on;
   logic [xonbuf_pkg::THR_W-1:0]  upper_thr;
   logic [xonbuf_pkg::THR_W-1:0]  lower_thr;
   logic [xonbuf_pkg::BYTE_W-1:0] eof_byte;

   rsp_beat_type expected_beats [$];

   int send_idle;
   int rcv_stall;
   int fail_count;
   int requests_sent;
   int beats_checked;
   int pops_seen;
   int drops_seen;
   int xoff_seen;
   int xon_seen;
   int stall_cycles;

   xon_xoff_receive_buffer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Work out the result of one request and advance the tracked state
   function automatic rsp_beat_type predict_buffer_step(logic op,
                                                        logic [xonbuf_pkg::BYTE_W-1:0] data);
      rsp_beat_type r;
      r = '{default: '0};
      if (op == xonbuf_pkg::OP_RX) begin
         if (rx_on) begin
            if (level < xonbuf_pkg::FIFO_DEPTH) begin
               ring[wr_ptr] = data;
               wr_ptr       = wr_ptr + 1'b1;
               level        = level + 1;
               r.end_seen   = (data == eof_byte);
            end else begin
               r.dropped = 1'b1;
            end
            if (level > int'(upper_thr)) begin
               rx_on        = 1'b0;
               r.flow_event = xonbuf_pkg::FLOW_XOFF;
            end
         end else begin
            r.dropped = 1'b1;
         end
      end else if (level > 0) begin
         if (level < int'(lower_thr) && !rx_on) begin
            rx_on        = 1'b1;
            r.flow_event = xonbuf_pkg::FLOW_XON;
         end
         r.pop_byte  = ring[rd_ptr];
         rd_ptr      = rd_ptr + 1'b1;
         level       = level - 1;
         r.pop_valid = 1'b1;
         r.end_seen  = (r.pop_byte == eof_byte);
      end
      r.fill_count = xonbuf_pkg::FILL_W'(level);
      r.receiving  = rx_on;
      return r;
   endfunction

   // Send one request beat; called at a falling edge, returns at a falling edge
   task automatic send_beat(input logic op, input logic [xonbuf_pkg::BYTE_W-1:0] data);
      while ($urandom_range(99) < send_idle) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.opcode  = op;
      req_if.rx_byte = data;
      do @(posedge clock); while (!req_if.ready);
      expected_beats.push_back(predict_buffer_step(op, data));
      requests_sent++;
      @(negedge clock);
   endtask

   // Hold off the sender until every result beat is back
   task automatic wait_drained();
      req_if.valid = 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write one register while the block is idle
   task automatic write_csr(input logic [xonbuf_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [xonbuf_pkg::CSR_DATA_W-1:0] data);
      wait_drained();
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we    = 1'b0;
      case (idx)
         xonbuf_pkg::CSR_UPPER:      upper_thr = data[xonbuf_pkg::THR_W-1:0];
         xonbuf_pkg::CSR_LOWER:      lower_thr = data[xonbuf_pkg::THR_W-1:0];
         xonbuf_pkg::CSR_END_MARKER: eof_byte  = data;
         default: ;
      endcase
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle = 0;  rcv_stall = 0;  end
         1: begin send_idle = 81; rcv_stall = 0;  end
         2: begin send_idle = 0;  rcv_stall = 81; end
         default: begin send_idle = 25; rcv_stall = 25; end
      endcase
   endtask

   // Data byte with a fair share of end markers
   function automatic logic [xonbuf_pkg::BYTE_W-1:0] pick_byte();
      if ($urandom_range(7) == 0) return eof_byte;
      return xonbuf_pkg::BYTE_W'($urandom_range(255));
   endfunction

   // Consume until the tracked store is empty
   task automatic drain_store();
      int n;
      n = level;
      repeat (n) send_beat(xonbuf_pkg::OP_CONSUME, pick_byte());
   endtask

   // Reset thresholds: XOFF on the sixth byte, XON on a consume while fewer than two are stored
   task automatic test_default_hysteresis();
      set_idling(0);
      send_beat(xonbuf_pkg::OP_CONSUME, 8'hFF);
      send_beat(xonbuf_pkg::OP_RX, 8'h00);
      send_beat(xonbuf_pkg::OP_RX, 8'hFF);
      send_beat(xonbuf_pkg::OP_RX, eof_byte);
      send_beat(xonbuf_pkg::OP_RX, 8'h55);
      send_beat(xonbuf_pkg::OP_RX, 8'hAA);
      send_beat(xonbuf_pkg::OP_RX, 8'h01);
      send_beat(xonbuf_pkg::OP_RX, 8'h3C);
      repeat (6) send_beat(xonbuf_pkg::OP_CONSUME, 8'h00);
   endtask

   // Fill the store past its depth, then lower the threshold while it is full
   task automatic test_full_store();
      set_idling(3);
      write_csr(xonbuf_pkg::CSR_UPPER, 8'hFF);
      write_csr(xonbuf_pkg::CSR_LOWER, 8'hE2);
      write_csr(xonbuf_pkg::CSR_END_MARKER, 8'hFF);
      write_csr(CSR_SPARE, 8'h00);
      for (int i = 0; i < xonbuf_pkg::FIFO_DEPTH - 1; i++)
         send_beat(xonbuf_pkg::OP_RX, xonbuf_pkg::BYTE_W'(i * 17));
      send_beat(xonbuf_pkg::OP_RX, 8'hFF);
      send_beat(xonbuf_pkg::OP_RX, 8'hFF);
      write_csr(xonbuf_pkg::CSR_UPPER, 8'h03);
      send_beat(xonbuf_pkg::OP_RX, 8'h7E);
   endtask

   // Random bursts of arrivals and consumes under one register setting
   task automatic run_random_phase(input int phase);
      int   left;
      int   burst;
      logic op;
      set_idling(phase % 4);
      case (phase)
         0: begin write_csr(xonbuf_pkg::CSR_UPPER, 8'h05);
                  write_csr(xonbuf_pkg::CSR_LOWER, 8'h02);
                  write_csr(xonbuf_pkg::CSR_END_MARKER, 8'h1A); end
         1: begin write_csr(xonbuf_pkg::CSR_UPPER, 8'h00);
                  write_csr(xonbuf_pkg::CSR_LOWER, 8'hF0);
                  write_csr(xonbuf_pkg::CSR_END_MARKER, 8'h00); end
         2: begin write_csr(xonbuf_pkg::CSR_UPPER, 8'h1F);
                  write_csr(xonbuf_pkg::CSR_LOWER, 8'h02);
                  write_csr(xonbuf_pkg::CSR_END_MARKER, 8'hFF); end
         3: begin write_csr(xonbuf_pkg::CSR_UPPER, 8'h0C);
                  write_csr(xonbuf_pkg::CSR_LOWER, 8'h08);
                  write_csr(xonbuf_pkg::CSR_END_MARKER,
                            xonbuf_pkg::BYTE_W'($urandom_range(255))); end
         4: begin write_csr(xonbuf_pkg::CSR_UPPER, 8'h10);
                  write_csr(xonbuf_pkg::CSR_LOWER, 8'hFF);
                  write_csr(xonbuf_pkg::CSR_END_MARKER, 8'h5A); end
         5: begin write_csr(xonbuf_pkg::CSR_UPPER, 8'h08);
                  write_csr(xonbuf_pkg::CSR_LOWER, 8'h03);
                  write_csr(xonbuf_pkg::CSR_END_MARKER, 8'h80); end
         6: begin write_csr(xonbuf_pkg::CSR_UPPER, 8'h0F);
                  write_csr(xonbuf_pkg::CSR_LOWER, 8'h02);
                  write_csr(xonbuf_pkg::CSR_END_MARKER,
                            xonbuf_pkg::BYTE_W'($urandom_range(255))); end
         default: begin write_csr(xonbuf_pkg::CSR_UPPER, 8'h03);
                  write_csr(xonbuf_pkg::CSR_LOWER, 8'h04);
                  write_csr(xonbuf_pkg::CSR_END_MARKER, 8'h1A); end
      endcase
      left = PHASE_ITEMS;
      while (left > 0) begin
         burst = $urandom_range(1, 20);
         op    = logic'($urandom_range(1));
         while (burst > 0 && left > 0) begin
            send_beat(op, pick_byte());
            burst--;
            left--;
            // let the pipeline empty once per phase
            if (left == PHASE_ITEMS / 2) wait_drained();
         end
      end
   endtask

   // Zero lower threshold: XOFF survives an empty store and no XON ever comes
   task automatic test_stuck_xoff();
      set_idling(0);
      drain_store();
      write_csr(xonbuf_pkg::CSR_UPPER, 8'hE0);
      write_csr(xonbuf_pkg::CSR_LOWER, 8'h00);
      write_csr(xonbuf_pkg::CSR_END_MARKER, 8'h00);
      send_beat(xonbuf_pkg::OP_RX, 8'h00);
      send_beat(xonbuf_pkg::OP_CONSUME, 8'hFF);
      send_beat(xonbuf_pkg::OP_CONSUME, 8'h00);
      send_beat(xonbuf_pkg::OP_RX, 8'hFF);
   endtask

   // Stimulus sequence
   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.opcode  = xonbuf_pkg::OP_RX;
      req_if.rx_byte = '0;
      send_idle      = 0;
      rcv_stall      = 0;
      rd_ptr         = '0;
      wr_ptr         = '0;
      level          = 0;
      rx_on          = 1'b1;
      upper_thr      = xonbuf_pkg::UPPER_RESET;
      lower_thr      = xonbuf_pkg::LOWER_RESET;
      eof_byte       = xonbuf_pkg::MARKER_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_hysteresis();
      test_full_store();
      for (int p = 0; p < PHASE_COUNT; p++) run_random_phase(p);
      test_stuck_xoff();

      wait_drained();
      repeat (2 * DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests over %0d register settings; checked %0d result beats",
               requests_sent, PHASE_COUNT + 3, beats_checked);
      $display("Seen %0d pops, %0d dropped bytes, %0d XOFF and %0d XON events",
               pops_seen, drops_seen, xoff_seen, xon_seen);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Receiver backpressure
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rcv_stall);
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_beat(input rsp_beat_type want);
      check_field("pop_valid",  8'(want.pop_valid),  8'(rsp_if.pop_valid));
      check_field("pop_byte",   want.pop_byte,       rsp_if.pop_byte);
      check_field("flow_event", 8'(want.flow_event), 8'(rsp_if.flow_event));
      check_field("dropped",    8'(want.dropped),    8'(rsp_if.dropped));
      check_field("end_seen",   8'(want.end_seen),   8'(rsp_if.end_seen));
      check_field("fill_count", 8'(want.fill_count), 8'(rsp_if.fill_count));
      check_field("receiving",  8'(want.receiving),  8'(rsp_if.receiving));
      beats_checked++;
      if (want.pop_valid) pops_seen++;
      if (want.dropped) drops_seen++;
      if (want.flow_event == xonbuf_pkg::FLOW_XOFF) xoff_seen++;
      if (want.flow_event == xonbuf_pkg::FLOW_XON) xon_seen++;
   endtask

   // Compare each result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_beats.size() == 0) begin
            $error("result beat with no request outstanding");
            fail_count++;
         end else begin
            check_beat(expected_beats.pop_front());
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
